/* rtl/core/i2cms_pkg.sv */
package i2cms_pkg;

  // default transmit store depth
  localparam int unsigned BUF_DEPTH_DEF = 256;

  // item opcodes
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_START_WR = 2'd1;
  localparam logic [1:0] OP_START_RD = 2'd2;
  localparam logic [1:0] OP_EVENT    = 2'd3;

  // transfer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TX   = 2'd1;
  localparam logic [1:0] PH_RX   = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  // completion codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ACK_FAIL = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_FIELDS_W = 38;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_FIELDS_W = 35;

  // input beat, tdata fields from the lowest bit up, opcode on top
  typedef struct packed {
    logic [1:0] opcode;
    logic       flag_ack_failure;
    logic       flag_rx_not_empty;
    logic       flag_byte_finished;
    logic       flag_tx_empty;
    logic       flag_address_sent;
    logic       flag_start_sent;
    logic [8:0] transfer_length;
    logic [6:0] device_address;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
  } item_t;

  // result beat, fields from the lowest bit up
  typedef struct packed {
    logic [1:0] transfer_state;
    logic [1:0] completion_status;
    logic       done_res;
    logic [7:0] rx_data;
    logic [7:0] rx_position;
    logic       rx_valid;
    logic       clear_ack;
    logic       set_ack;
    logic       generate_stop;
    logic       generate_start;
    logic [7:0] write_data;
    logic       write_data_valid;
  } result_t;

  // sequencer state
  typedef struct packed {
    logic [1:0] phase;
    logic [8:0] byte_count;
    logic [8:0] length_in_use;
    logic [6:0] target_address;
  } seq_state_t;

  // byte counter control toward the store pointer
  typedef struct packed {
    logic count_clear;
    logic count_advance;
  } count_ctl_t;

endpackage

/* rtl/core/i2cms_ram.sv */
module i2cms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/i2cms_decode.sv */
module i2cms_decode
  import i2cms_pkg::*;
(
  input  item_t      item,
  input  seq_state_t cur,
  input  logic [7:0] tx_byte,
  output seq_state_t nxt,
  output count_ctl_t cnt,
  output result_t    res
);

  logic [8:0] count_inc;
  logic [8:0] length_dec;

  assign count_inc  = cur.byte_count + 9'd1;
  assign length_dec = cur.length_in_use - 9'd1;

  always_comb begin
    nxt = cur;
    cnt = '0;
    res = '0;

    unique case (item.opcode)
      OP_LOAD: begin
        // store write happens at acceptance, nothing to do here
      end
      OP_START_WR, OP_START_RD: begin
        if (cur.phase != PH_IDLE) begin
          res.done_res          = 1'b1;
          res.completion_status = ST_BUSY;
        end else begin
          nxt.length_in_use  = item.transfer_length;
          nxt.byte_count     = 9'd0;
          nxt.target_address = item.device_address;
          nxt.phase          = (item.opcode == OP_START_WR) ? PH_TX : PH_RX;
          cnt.count_clear    = 1'b1;
          res.generate_start = 1'b1;
          res.set_ack        = (item.opcode == OP_START_RD);
        end
      end
      OP_EVENT: begin
        // status flags in priority order
        if (item.flag_start_sent) begin
          res.write_data_valid = 1'b1;
          res.write_data       = {cur.target_address, (cur.phase != PH_TX)};
        end else if (item.flag_address_sent) begin
          if (cur.phase == PH_RX && cur.length_in_use == 9'd1) begin
            res.clear_ack     = 1'b1;
            res.generate_stop = 1'b1;
          end
        end else if (item.flag_tx_empty && cur.phase == PH_TX) begin
          if (cur.byte_count < cur.length_in_use) begin
            res.write_data_valid = 1'b1;
            res.write_data       = tx_byte;
            nxt.byte_count       = count_inc;
            cnt.count_advance    = 1'b1;
          end else if (item.flag_byte_finished) begin
            res.generate_stop     = 1'b1;
            nxt.phase             = PH_IDLE;
            res.done_res          = 1'b1;
            res.completion_status = ST_OK;
          end
        end else if (item.flag_rx_not_empty && cur.phase == PH_RX) begin
          res.rx_valid      = 1'b1;
          res.rx_position   = cur.byte_count[7:0];
          res.rx_data       = item.data_byte;
          nxt.byte_count    = count_inc;
          cnt.count_advance = 1'b1;
          if (count_inc == length_dec) begin
            res.clear_ack     = 1'b1;
            res.generate_stop = 1'b1;
          end
          if (count_inc >= cur.length_in_use) begin
            nxt.phase             = PH_IDLE;
            res.done_res          = 1'b1;
            res.completion_status = ST_OK;
          end
        end else if (item.flag_ack_failure) begin
          res.generate_stop     = 1'b1;
          nxt.phase             = PH_ERR;
          res.done_res          = 1'b1;
          res.completion_status = ST_ACK_FAIL;
        end
      end
      default: begin
      end
    endcase

    res.transfer_state = nxt.phase;
  end

endmodule

/* rtl/core/i2c_master_event_sequencer.sv */
// I2C master transfer sequencer driven by controller status events. Every beat,
// whether a transmit-byte load, a start request or a status event, yields exactly
// one result beat. One beat is taken per clock cycle unless the result side stalls;
// each beat passes the input register, then the result register, and stalls on
// the result side back up through those two stages only. The transmit store is a
// BUF_DEPTH-byte RAM written when a load beat is accepted and read, for the byte
// the next transmit event will need, in that same acceptance cycle, so its one
// read port sets no limit on rate. The store has no clearing pass: sending a byte
// that was never loaded gives an unspecified value. After an acknowledge failure
// the block stays in error, rejecting starts, until reset.
module i2c_master_event_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // byte_index, data_byte, device_address, transfer_length, flag_start_sent,
  // flag_address_sent, flag_tx_empty, flag_byte_finished, flag_rx_not_empty,
  // flag_ack_failure, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // write_data_valid, write_data, generate_start, generate_stop, set_ack,
  // clear_ack, rx_valid, rx_position, rx_data, done_res, completion_status,
  // transfer_state, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(BUF_DEPTH - 1);

  item_t      s_item;
  item_t      in_item;
  logic       in_valid;
  result_t    out_res;
  logic       out_valid;
  seq_state_t state;
  seq_state_t state_next;
  count_ctl_t cnt;
  result_t    res;
  logic [AW-1:0] tx_ptr;
  logic [AW-1:0] tx_ptr_next;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] load_addr;
  logic [7:0]    tx_rdata;
  logic          accept;
  logic          process;

  assign s_item        = {s_axis_tuser, s_axis_tdata[IN_FIELDS_W-1:0]};
  assign process       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || process;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // load position wrapped into the store
  if (BUF_DEPTH >= 256) begin : g_idx_direct
    assign load_addr = AW'(s_item.byte_index);
  end else begin : g_idx_wrap
    logic [AW-1:0] wrap_tab [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_tab
      localparam int unsigned WrapIdx = gi % BUF_DEPTH;
      assign wrap_tab[gi] = AW'(WrapIdx);
    end
    assign load_addr = wrap_tab[s_item.byte_index];
  end

  // store pointer follows byte_count modulo the depth
  always_comb begin
    tx_ptr_next = tx_ptr;
    if (cnt.count_clear) begin
      tx_ptr_next = '0;
    end else if (cnt.count_advance) begin
      // the 9-bit byte count wraps to zero, the pointer wraps with it
      tx_ptr_next = (tx_ptr == PTR_LAST || state.byte_count == 9'h1FF) ? '0
                                                                        : tx_ptr + AW'(1);
    end
  end

  // read address is the pointer the accepted beat will see
  assign rd_ptr = process ? tx_ptr_next : tx_ptr;

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_tx_store (
    .clk     (clk),
    .wr_en   (accept && s_item.opcode == OP_LOAD),
    .wr_addr (load_addr),
    .wr_data (s_item.data_byte),
    .rd_en   (accept),
    .rd_addr (rd_ptr),
    .rd_data (tx_rdata)
  );

  i2cms_decode u_decode (
    .item    (in_item),
    .cur     (state),
    .tx_byte (tx_rdata),
    .nxt     (state_next),
    .cnt     (cnt),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
    if (accept) begin
      in_item <= s_item;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '{phase: PH_IDLE, byte_count: '0, length_in_use: '0,
                  target_address: '0};
      tx_ptr <= '0;
    end else if (process) begin
      state  <= state_next;
      tx_ptr <= tx_ptr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (process) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_res};

  // error phase is left only through reset
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_ERR) |=> (state.phase == PH_ERR))
    else $error("error phase left without reset");

  // a successful completion always leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_res && out_res.completion_status == ST_OK)
      |-> (out_res.transfer_state == PH_IDLE))
    else $error("ok completion reported while not idle");

  // transmit count never passes the length
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_TX) |-> (state.byte_count <= state.length_in_use))
    else $error("transmit count beyond length");

  // store pointer tracks the byte counter
  assert property (@(posedge clk) disable iff (rst)
    (state.byte_count == 9'd0) |-> (tx_ptr == '0))
    else $error("store pointer out of step with byte count");

endmodule

/* dv/i2c_master_event_sequencer_tb.sv */
`timescale 1ns / 1ps

module i2c_master_event_sequencer_tb
  import i2cms_pkg::*;
();

  // status flag masks, ordered {ack_failure, rx_not_empty, byte_finished,
  // tx_empty, address_sent, start_sent}
  localparam logic [5:0] EV_NONE       = 6'h00;
  localparam logic [5:0] EV_START_SENT = 6'h01;
  localparam logic [5:0] EV_ADDR_SENT  = 6'h02;
  localparam logic [5:0] EV_TX_EMPTY   = 6'h04;
  localparam logic [5:0] EV_BYTE_FIN   = 6'h08;
  localparam logic [5:0] EV_RX_NE      = 6'h10;
  localparam logic [5:0] EV_ACK_FAIL   = 6'h20;

  // transfer progress as seen by the stimulus
  localparam int STEP_START_SENT = 0;
  localparam int STEP_ADDR_SENT  = 1;
  localparam int STEP_DATA       = 2;

  localparam int ITEM_TARGET = 1700;
  localparam int QUIET_FROM  = 1450;

  // transfer sequencer model and queue of responses still owed by the block
  class sequencer_model;
    logic [1:0] phase;
    logic [8:0] byte_count;
    logic [8:0] length_in_use;
    logic [6:0] target_address;
    logic [7:0] tx_bytes [256];
    bit         loaded [256];
    result_t    due_responses [$];
    int         mismatches;

    function new();
      phase = PH_IDLE;
      byte_count = '0;
      length_in_use = '0;
      target_address = '0;
      mismatches = 0;
      for (int i = 0; i < 256; i++) begin
        loaded[i] = 1'b0;
        tx_bytes[i] = '0;
      end
    endfunction

    // advance the model by one accepted input beat
    function void note_item(item_t it);
      result_t r;
      r = '0;
      case (it.opcode)
        OP_LOAD: begin
          tx_bytes[it.byte_index] = it.data_byte;
          loaded[it.byte_index] = 1'b1;
        end
        OP_START_WR, OP_START_RD: begin
          if (phase != PH_IDLE) begin
            r.done_res = 1'b1;
            r.completion_status = ST_BUSY;
          end else begin
            length_in_use = it.transfer_length;
            byte_count = '0;
            target_address = it.device_address;
            phase = (it.opcode == OP_START_WR) ? PH_TX : PH_RX;
            r.generate_start = 1'b1;
            r.set_ack = (it.opcode == OP_START_RD);
          end
        end
        default: begin
          // status flags in priority order
          if (it.flag_start_sent) begin
            r.write_data_valid = 1'b1;
            r.write_data = {target_address, phase != PH_TX};
          end else if (it.flag_address_sent) begin
            if (phase == PH_RX && length_in_use == 9'd1) begin
              r.clear_ack = 1'b1;
              r.generate_stop = 1'b1;
            end
          end else if (it.flag_tx_empty && phase == PH_TX) begin
            if (byte_count < length_in_use) begin
              r.write_data_valid = 1'b1;
              r.write_data = tx_bytes[byte_count[7:0]];
              byte_count = byte_count + 9'd1;
            end else if (it.flag_byte_finished) begin
              r.generate_stop = 1'b1;
              phase = PH_IDLE;
              r.done_res = 1'b1;
              r.completion_status = ST_OK;
            end
          end else if (it.flag_rx_not_empty && phase == PH_RX) begin
            r.rx_valid = 1'b1;
            r.rx_position = byte_count[7:0];
            r.rx_data = it.data_byte;
            byte_count = byte_count + 9'd1;
            // nack and stop go out before the last byte
            if (byte_count == length_in_use - 9'd1) begin
              r.clear_ack = 1'b1;
              r.generate_stop = 1'b1;
            end
            if (byte_count >= length_in_use) begin
              phase = PH_IDLE;
              r.done_res = 1'b1;
              r.completion_status = ST_OK;
            end
          end else if (it.flag_ack_failure) begin
            r.generate_stop = 1'b1;
            phase = PH_ERR;
            r.done_res = 1'b1;
            r.completion_status = ST_ACK_FAIL;
          end
        end
      endcase
      r.transfer_state = phase;
      due_responses.push_back(r);
    endfunction

    function bit field_differs(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b0;
      if (mismatches < 10)
        $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
      return 1'b1;
    endfunction

    // compare one result beat with the oldest owed response
    function void check_response(logic [OUT_TDATA_W-1:0] beat);
      result_t want;
      result_t got;
      bit      bad;
      got = beat[OUT_FIELDS_W-1:0];
      if (due_responses.size() == 0) begin
        if (mismatches < 10) $display("%0t: result beat with none owed: %h", $realtime, beat);
        mismatches++;
        return;
      end
      want = due_responses.pop_front();
      bad = 1'b0;
      bad |= field_differs("write_data_valid", want.write_data_valid, got.write_data_valid);
      bad |= field_differs("write_data", want.write_data, got.write_data);
      bad |= field_differs("generate_start", want.generate_start, got.generate_start);
      bad |= field_differs("generate_stop", want.generate_stop, got.generate_stop);
      bad |= field_differs("set_ack", want.set_ack, got.set_ack);
      bad |= field_differs("clear_ack", want.clear_ack, got.clear_ack);
      bad |= field_differs("rx_valid", want.rx_valid, got.rx_valid);
      bad |= field_differs("rx_position", want.rx_position, got.rx_position);
      bad |= field_differs("rx_data", want.rx_data, got.rx_data);
      bad |= field_differs("done_res", want.done_res, got.done_res);
      bad |= field_differs("completion_status", want.completion_status,
                           got.completion_status);
      bad |= field_differs("transfer_state", want.transfer_state, got.transfer_state);
      bad |= field_differs("pad", 0, beat[OUT_TDATA_W-1:OUT_FIELDS_W]);
      if (bad) mismatches++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OP_LOAD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sequencer_model model = new();
  bit             quiet_tail = 1'b0;
  int             gap_pct = 10;
  int             seq_step = STEP_START_SENT;

  i2c_master_event_sequencer i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("i2c_master_event_sequencer verification failed");
    $finish;
  end

  // result side: ready with random stall bursts, pressure varies over time
  initial begin
    int stall_pct;
    int cyc;
    stall_pct = 0;
    cyc = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) model.check_response(m_axis_tdata);
  end

  // beat with random payload, given opcode and no flags
  function automatic item_t blank_item(logic [1:0] op);
    item_t it;
    it = '0;
    it.opcode = op;
    it.byte_index = 8'($urandom);
    it.data_byte = 8'($urandom);
    it.device_address = 7'($urandom);
    it.transfer_length = 9'($urandom);
    return it;
  endfunction

  function automatic item_t event_item(logic [5:0] flags);
    item_t it;
    it = blank_item(OP_EVENT);
    {it.flag_ack_failure, it.flag_rx_not_empty, it.flag_byte_finished,
     it.flag_tx_empty, it.flag_address_sent, it.flag_start_sent} = flags;
    return it;
  endfunction

  function automatic item_t load_item(logic [7:0] idx, logic [7:0] value);
    item_t it;
    it = blank_item(OP_LOAD);
    it.byte_index = idx;
    it.data_byte = value;
    return it;
  endfunction

  function automatic item_t start_item(logic [1:0] op, logic [6:0] addr, logic [8:0] len);
    item_t it;
    it = blank_item(op);
    it.device_address = addr;
    it.transfer_length = len;
    return it;
  endfunction

  // mostly short transfers, a few long ones
  function automatic logic [8:0] pick_length();
    int r;
    r = $urandom_range(0, 999);
    if (r < 800) return 9'($urandom_range(0, 6));
    if (r < 950) return 9'($urandom_range(7, 40));
    if (r < 995) return 9'($urandom_range(41, 256));
    return 9'($urandom_range(257, 511));
  endfunction

  // random flags; ack failure only where a higher flag takes precedence
  function automatic item_t noise_event();
    logic [5:0] flags;
    flags = 6'($urandom) & ~EV_ACK_FAIL;
    if ((flags & (EV_START_SENT | EV_ADDR_SENT)) != EV_NONE && $urandom_range(0, 1))
      flags = flags | EV_ACK_FAIL;
    return event_item(flags);
  endfunction

  // next well-formed beat of the running transfer
  function automatic item_t progress_item();
    logic [5:0] extra;
    extra = 6'($urandom);
    case (seq_step)
      STEP_START_SENT: return event_item(EV_START_SENT | extra);
      STEP_ADDR_SENT: return event_item(EV_ADDR_SENT | (extra & ~EV_START_SENT));
      default: begin
        extra = extra & ~(EV_START_SENT | EV_ADDR_SENT | EV_TX_EMPTY | EV_RX_NE);
        if (model.phase == PH_TX) begin
          if (model.byte_count >= model.length_in_use)
            extra = ($urandom_range(0, 9) < 7) ? (extra | EV_BYTE_FIN) : (extra & ~EV_BYTE_FIN);
          return event_item(EV_TX_EMPTY | extra);
        end
        return event_item(EV_RX_NE | extra);
      end
    endcase
  endfunction

  // never send a byte from a store entry that was not loaded: load it first
  function automatic item_t keep_store_defined(item_t it);
    item_t fixed;
    fixed = it;
    if (it.opcode == OP_EVENT && !it.flag_start_sent && !it.flag_address_sent &&
        it.flag_tx_empty && model.phase == PH_TX &&
        model.byte_count < model.length_in_use && !model.loaded[model.byte_count[7:0]])
      fixed = load_item(model.byte_count[7:0], 8'($urandom));
    return fixed;
  endfunction

  // drive one beat and wait for it to be taken
  task automatic send_item(item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, it[IN_FIELDS_W-1:0]};
    s_axis_tuser <= it.opcode;
    do @(posedge clk); while (!s_axis_tready);
    model.note_item(it);
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    item_t it;
    int    counted;
    int    transfers;
    bit    is_noise;
    bit    is_progress;

    counted = 0;
    transfers = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two-byte write with wait for byte finished
    send_item(load_item(8'd0, 8'h00));
    send_item(load_item(8'd255, 8'hFF));
    send_item(load_item(8'd1, 8'hA5));
    send_item(start_item(OP_START_WR, 7'd127, 9'd2));
    send_item(start_item(OP_START_RD, 7'd3, 9'd5));
    send_item(event_item(EV_START_SENT));
    send_item(event_item(EV_ADDR_SENT));
    send_item(event_item(EV_NONE));
    send_item(event_item(EV_TX_EMPTY));
    send_item(event_item(EV_TX_EMPTY | EV_BYTE_FIN));
    send_item(event_item(EV_TX_EMPTY));
    send_item(event_item(EV_TX_EMPTY | EV_BYTE_FIN));
    // one-byte read: nack and stop at address sent
    send_item(start_item(OP_START_RD, 7'd0, 9'd1));
    send_item(event_item(EV_START_SENT));
    send_item(event_item(EV_ADDR_SENT));
    send_item(event_item(EV_RX_NE));
    // zero-length write and read
    send_item(start_item(OP_START_WR, 7'h55, 9'd0));
    send_item(event_item(EV_START_SENT));
    send_item(event_item(EV_TX_EMPTY | EV_BYTE_FIN));
    send_item(start_item(OP_START_RD, 7'h2A, 9'd0));
    send_item(event_item(EV_RX_NE));
    // flags while idle
    send_item(event_item(EV_START_SENT));
    send_item(event_item(EV_ADDR_SENT | EV_TX_EMPTY | EV_RX_NE));

    // random transfers with noise
    while (counted < ITEM_TARGET) begin
      quiet_tail = (counted >= QUIET_FROM);
      if (counted % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
      end
      is_noise = 1'b0;
      is_progress = 1'b0;
      if (model.phase == PH_IDLE) begin
        case ($urandom_range(0, 9))
          0, 1: it = load_item(8'($urandom), 8'($urandom));
          2: begin
            it = noise_event();
            is_noise = 1'b1;
          end
          default: begin
            transfers++;
            if (transfers == 4)
              it = start_item(OP_START_RD, 7'($urandom), 9'($urandom_range(257, 280)));
            else
              it = start_item($urandom_range(0, 1) ? OP_START_WR : OP_START_RD,
                              7'($urandom), pick_length());
            seq_step = STEP_START_SENT;
          end
        endcase
      end else if ($urandom_range(0, 99) < 85) begin
        it = progress_item();
        is_progress = 1'b1;
      end else begin
        case ($urandom_range(0, 2))
          0: it = load_item(8'($urandom), 8'($urandom));
          1: it = start_item($urandom_range(0, 1) ? OP_START_WR : OP_START_RD,
                             7'($urandom), 9'($urandom));
          default: begin
            it = noise_event();
            is_noise = 1'b1;
          end
        endcase
      end
      it = keep_store_defined(it);
      if (it.opcode != OP_EVENT) is_progress = 1'b0;
      send_item(it);
      if (is_progress && seq_step < STEP_DATA) seq_step++;
      if (!is_noise) counted++;
    end

    // acknowledge failure, then the error phase holds until reset
    if (model.phase == PH_IDLE) begin
      send_item(start_item(OP_START_WR, 7'($urandom), 9'($urandom_range(1, 4))));
      send_item(event_item(EV_START_SENT));
    end
    send_item(event_item(EV_ACK_FAIL));
    send_item(start_item(OP_START_WR, 7'($urandom), 9'd3));
    send_item(start_item(OP_START_RD, 7'($urandom), 9'd1));
    send_item(event_item(EV_START_SENT));
    send_item(event_item(EV_ADDR_SENT));
    send_item(event_item(EV_TX_EMPTY | EV_BYTE_FIN));
    send_item(event_item(EV_RX_NE));
    send_item(load_item(8'($urandom), 8'($urandom)));
    send_item(event_item(EV_ACK_FAIL));
    send_item(event_item(EV_NONE));
    s_axis_tvalid <= 1'b0;

    // drain owed responses, then let the pipeline settle
    while (model.due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (model.mismatches == 0 && model.due_responses.size() == 0) begin
      $display("i2c_master_event_sequencer verification clean");
    end else begin
      $display("i2c_master_event_sequencer verification failed");
    end
    $finish;
  end

endmodule
